FILE: hw/rtl/spr_pkg.sv
// Shared types and constants for the stream pattern redactor.
`default_nettype none

package spr_pkg;

	// Byte codes used by the redactor.
	localparam logic [7:0] FILL_BYTE    = 8'h23;
	localparam logic [7:0] A_BYTE       = 8'h61;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	// Results caused by one input byte never exceed this count.
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = 5;

	// Output queue depth (power of two).
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HI  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_LOOP
	} st_t;

	// Per-cell window control.
	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

	// One queued output run: a byte repeated cnt times, last marks the end of a step.
	typedef struct packed {
		logic [7:0]       value;
		logic [CNT_W-1:0] cnt;
		logic             last;
	} entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spr_cell.sv
// One window cell: holds a pending byte and compares it with its pattern byte.
`default_nettype none

module spr_cell (
	input  wire                    clk,
	input  wire [7:0]              pat_byte,
	input  wire                    en,
	input  wire [7:0]              in_byte,
	input  wire [7:0]              nbr_view,
	input  spr_pkg::cell_ctl_t     ctl,
	output logic [7:0]             view,
	output logic                   hit
);

	logic [7:0] win_q;

	// The cell sees the incoming byte when it is the insertion point.
	assign view = ctl.ins ? in_byte : win_q;

	// Cells beyond the pattern length always agree.
	assign hit = !en || (view == pat_byte);

	// Shift from the right neighbor or take the incoming byte.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			win_q <= nbr_view;
		end else if (ctl.ins) begin
			win_q <= in_byte;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/spr_outq.sv
// Output queue of byte runs with an expanding output register.
`default_nettype none

module spr_outq (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  spr_pkg::entry_t     push_entry,
	output logic                full,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [7:0]          m_tdata,  // [7:0] out_byte
	output logic                m_tlast
);

	spr_pkg::entry_t                   mem_q [spr_pkg::QUEUE_DEPTH];
	logic [spr_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [spr_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [spr_pkg::QPTR_W:0]          count_q;
	logic                              ov_q;
	logic [7:0]                        ob_q;
	logic [spr_pkg::CNT_W-1:0]         rem_q;
	logic                              olast_q;
	logic                              empty;
	logic                              done;
	logic                              pop;

	assign full  = (count_q == (spr_pkg::QPTR_W + 1)'(spr_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);

	// The current run finishes on the transaction of its final byte.
	assign done = ov_q && m_tready && (rem_q == spr_pkg::CNT_W'(1));
	assign pop  = !empty && (!ov_q || done);

	assign m_tvalid = ov_q;
	assign m_tdata  = ob_q;
	assign m_tlast  = olast_q && (rem_q == spr_pkg::CNT_W'(1));

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + spr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + spr_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (spr_pkg::QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (spr_pkg::QPTR_W + 1)'(1);
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (pop) begin
			ov_q <= 1'b1;
		end else if (done) begin
			ov_q <= 1'b0;
		end
	end

	// Output run payload and remaining repeat count.
	always_ff @(posedge clk) begin
		if (pop) begin
			ob_q    <= mem_q[rd_ptr_q].value;
			rem_q   <= mem_q[rd_ptr_q].cnt;
			olast_q <= mem_q[rd_ptr_q].last;
		end else if (ov_q && m_tready) begin
			rem_q <= rem_q - spr_pkg::CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/stream_pattern_redactor_core.sv
// Top level of the stream pattern redactor: window cell chain, sequencer and output queue.
//
// Usage: bytes enter on the s_ stream channel (s_tdata holds one byte, 8'h0A ends a line)
// and redacted bytes leave on the m_ stream channel. m_tlast marks the final output byte
// caused by one input byte. Each leftmost match of the pattern within a line is replaced
// by one '#' per 'a' in the pattern; other bytes pass through once they can no longer
// start a match. The pattern and its length are set through cfg_we/cfg_index/cfg_data
// while the block is idle.
// Throughput: one byte per cycle for ordinary bytes while the output queue is not full. A
// newline that finds pending bytes holds the input while the pending window bytes and then
// the newline are queued. After the pattern length has been lowered below the window fill,
// the next byte holds the input while the window drains. A match costs one queue entry
// however many '#' it emits; the output register expands it at one byte per cycle while
// m_tready is high. For an ordinary byte the output run enters the queue at the input
// transaction and then moves into the output register, which raises m_tvalid.
// Reset clears the window, the queue and the pattern (length one). When the receiver
// stalls, the small output queue fills and s_tready drops; nothing is lost.
`default_nettype none

module stream_pattern_redactor_core #(
	parameter int MAX_PATTERN = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [7:0]                       s_tdata,   // [7:0] in_byte
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [7:0]                       m_tdata,   // [7:0] out_byte
	output logic                             m_tlast,
	input  wire                              cfg_we,
	input  wire  [spr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [63:0]                      cfg_data
);

	localparam int FW = $clog2(MAX_PATTERN + 1);
	localparam int CW = spr_pkg::CNT_W;

	logic [63:0]             pat_lo_q;
	logic [63:0]             pat_hi_q;
	logic [4:0]              pat_len_q;
	logic [FW-1:0]           len;
	logic [MAX_PATTERN-1:0]  en;
	logic [MAX_PATTERN-1:0]  hit;
	logic [MAX_PATTERN-1:0]  is_a;
	logic [7:0]              pat_b [MAX_PATTERN];
	logic [7:0]              view  [MAX_PATTERN+1];
	logic [CW-1:0]           hashes;
	logic                    match;

	spr_pkg::st_t            state_q, state_d;
	logic [FW-1:0]           fill_q, fill_d;
	logic [FW-1:0]           drop_q, drop_d;
	logic                    held_vld_q, held_vld_d;
	spr_pkg::entry_t         held_q, held_d;
	logic [CW-1:0]           emit_q, emit_d;
	logic [FW-1:0]           fill_inc;
	logic [FW-1:0]           fill_dec;
	logic [CW-1:0]           room;
	logic [CW-1:0]           e_cnt;
	logic [CW-1:0]           clip;
	logic                    shift;
	logic                    push;
	spr_pkg::entry_t         push_entry;
	logic                    q_full;
	logic                    acc;
	logic                    is_nl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spr_pkg::REG_PAT_LO:  pat_lo_q  <= cfg_data;
				spr_pkg::REG_PAT_HI:  pat_hi_q  <= cfg_data;
				spr_pkg::REG_PAT_LEN: pat_len_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Effective pattern length, clamped to one through MAX_PATTERN.
	always_comb begin
		if (pat_len_q == 5'd0) begin
			len = FW'(1);
		end else if (pat_len_q > 5'(MAX_PATTERN)) begin
			len = FW'(MAX_PATTERN);
		end else begin
			len = FW'(pat_len_q);
		end
	end

	// Input handshake.
	assign s_tready = (state_q == spr_pkg::ST_RUN) && !q_full;
	assign acc      = s_tvalid && s_tready;
	assign is_nl    = (s_tdata == spr_pkg::NEWLINE_BYTE);

	assign view[MAX_PATTERN] = 8'h00;

	// Chain of window cells, cell zero at the front of the window.
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		spr_pkg::cell_ctl_t ctl;

		if (i < 8) begin : g_lo
			assign pat_b[i] = pat_lo_q[8*i +: 8];
		end else begin : g_hi
			assign pat_b[i] = pat_hi_q[8*(i-8) +: 8];
		end

		assign en[i]     = (FW'(i) < len);
		assign is_a[i]   = en[i] && (pat_b[i] == spr_pkg::A_BYTE);
		assign ctl.ins   = acc && !is_nl && (fill_q == FW'(i));
		assign ctl.shift = shift;

		spr_cell u_cell (
			.clk      (clk),
			.pat_byte (pat_b[i]),
			.en       (en[i]),
			.in_byte  (s_tdata),
			.nbr_view (view[i+1]),
			.ctl      (ctl),
			.view     (view[i]),
			.hit      (hit[i])
		);
	end

	assign match = &hit;

	// Number of '#' bytes that replace one match.
	always_comb begin
		hashes = '0;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			hashes = hashes + CW'(is_a[k]);
		end
	end

	assign fill_inc = fill_q + FW'(1);
	assign fill_dec = fill_q - FW'(1);

	// Results of one drain iteration, limited to the per-byte result budget.
	assign room  = CW'(spr_pkg::MAX_RESULTS) - emit_q;
	assign e_cnt = match ? hashes : CW'(1);
	assign clip  = (e_cnt < room) ? e_cnt : room;

	// Sequencer: next state, window control and queue writes.
	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		drop_d     = drop_q;
		held_vld_d = held_vld_q;
		held_d     = held_q;
		emit_d     = emit_q;
		shift      = 1'b0;
		push       = 1'b0;
		push_entry = '{value: view[0], cnt: CW'(1), last: 1'b1};
		unique case (state_q)
			spr_pkg::ST_RUN: begin
				if (acc) begin
					if (is_nl) begin
						if (fill_q == '0) begin
							push       = 1'b1;
							push_entry = '{value: spr_pkg::NEWLINE_BYTE, cnt: CW'(1),
								last: 1'b1};
						end else begin
							state_d = spr_pkg::ST_FLUSH;
						end
					end else if (fill_q >= len) begin
						// Window longer than the pattern: drain it in the loop state.
						fill_d     = fill_inc;
						state_d    = spr_pkg::ST_LOOP;
						held_vld_d = 1'b0;
						emit_d     = '0;
						drop_d     = '0;
					end else if (fill_inc < len) begin
						fill_d = fill_inc;
					end else if (match) begin
						fill_d = '0;
						if (hashes != '0) begin
							push       = 1'b1;
							push_entry = '{value: spr_pkg::FILL_BYTE, cnt: hashes,
								last: 1'b1};
						end
					end else begin
						push   = 1'b1;
						shift  = 1'b1;
						fill_d = fill_q;
					end
				end
			end
			spr_pkg::ST_FLUSH: begin
				if (!q_full) begin
					push = 1'b1;
					if (fill_q != '0) begin
						push_entry.last = 1'b0;
						shift           = 1'b1;
						fill_d          = fill_dec;
					end else begin
						push_entry = '{value: spr_pkg::NEWLINE_BYTE, cnt: CW'(1),
							last: 1'b1};
						state_d    = spr_pkg::ST_RUN;
					end
				end
			end
			spr_pkg::ST_LOOP: begin
				if (!q_full) begin
					if (drop_q != '0) begin
						// Skip the rest of a matched run.
						shift  = 1'b1;
						fill_d = fill_dec;
						drop_d = drop_q - FW'(1);
					end else if (fill_q < len) begin
						// Drained: release the held run as the final one.
						if (held_vld_q) begin
							push            = 1'b1;
							push_entry      = held_q;
							push_entry.last = 1'b1;
						end
						held_vld_d = 1'b0;
						state_d    = spr_pkg::ST_RUN;
					end else begin
						shift  = 1'b1;
						fill_d = fill_dec;
						if (match) begin
							drop_d = len - FW'(1);
						end
						if (clip != '0) begin
							if (held_vld_q) begin
								push            = 1'b1;
								push_entry      = held_q;
								push_entry.last = 1'b0;
							end
							held_vld_d = 1'b1;
							held_d     = '{value: match ? spr_pkg::FILL_BYTE : view[0],
								cnt: clip, last: 1'b0};
							emit_d     = emit_q + clip;
						end
					end
				end
			end
			default: state_d = spr_pkg::ST_RUN;
		endcase
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= spr_pkg::ST_RUN;
			fill_q     <= '0;
			drop_q     <= '0;
			held_vld_q <= 1'b0;
			emit_q     <= '0;
		end else begin
			state_q    <= state_d;
			fill_q     <= fill_d;
			drop_q     <= drop_d;
			held_vld_q <= held_vld_d;
			emit_q     <= emit_d;
		end
	end

	// Held run payload.
	always_ff @(posedge clk) begin
		held_q <= held_d;
	end

	spr_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

FILE: dv/spr_checker.sv
// Checker for the stream pattern redactor: predicts the redacted byte stream and compares it.

module spr_checker #(
	parameter int MAX_PATTERN = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	input  wire                           s_tready,
	input  wire  [7:0]                    s_tdata,   // [7:0] in_byte
	input  wire                           m_tvalid,
	input  wire                           m_tready,
	input  wire  [7:0]                    m_tdata,   // [7:0] out_byte
	input  wire                           m_tlast,
	input  wire                           cfg_we,
	input  wire  [spr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [63:0]                   cfg_data,
	output int                            fail_count,
	output int                            pending
);

	// One expected output byte and its end-of-step flag.
	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} redacted_byte_t;

	// Shadow copy of the pattern registers.
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [4:0]  pat_len;

	// Shadow copy of the pending-byte window.
	logic [7:0]  win [MAX_PATTERN];
	int unsigned win_fill;

	// Output bytes still owed by the block, oldest first.
	redacted_byte_t redacted_q[$];
	int unsigned    step_cnt;

	function automatic logic [7:0] pat_byte(int unsigned i);
		if (i < 8)
			return pat_lo[8*i +: 8];
		return pat_hi[8*(i-8) +: 8];
	endfunction

	// Queue one output byte of the current step, capped at the per-step maximum.
	function automatic void owe_byte(logic [7:0] v);
		if (step_cnt < spr_pkg::MAX_RESULTS) begin
			redacted_q.push_back('{value: v, last: 1'b0});
			step_cnt++;
		end
	endfunction

	// Remove k bytes from the front of the window.
	function automatic void drop_pending(int unsigned k);
		int unsigned i;
		for (i = 0; i + k < win_fill; i++)
			win[i] = win[i + k];
		win_fill -= k;
	endfunction

	// Work out the output bytes that one accepted input byte causes.
	task automatic predict_redaction(input logic [7:0] b);
		int unsigned    len;
		int unsigned    hashes;
		int unsigned    i;
		bit             hit;
		redacted_byte_t tail;
		step_cnt = 0;
		if (b == spr_pkg::NEWLINE_BYTE) begin
			// A line end flushes the window unchanged, then passes itself.
			for (i = 0; i < win_fill; i++)
				owe_byte(win[i]);
			win_fill = 0;
			owe_byte(spr_pkg::NEWLINE_BYTE);
		end else begin
			// Length zero acts as one, lengths above the window act as the window size.
			len = (pat_len == 5'd0) ? 1 :
				((pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len);
			hashes = 0;
			for (i = 0; i < len; i++)
				if (pat_byte(i) == spr_pkg::A_BYTE)
					hashes++;
			if (win_fill < MAX_PATTERN) begin
				win[win_fill] = b;
				win_fill++;
			end
			// Retry from the window front until too few bytes remain to match.
			while (win_fill >= len) begin
				hit = 1'b1;
				for (i = 0; i < len; i++)
					if (win[i] != pat_byte(i))
						hit = 1'b0;
				if (hit) begin
					repeat (hashes) owe_byte(spr_pkg::FILL_BYTE);
					drop_pending(len);
				end else begin
					owe_byte(win[0]);
					drop_pending(1);
				end
			end
		end
		if (step_cnt > 0) begin
			tail = redacted_q.pop_back();
			tail.last = 1'b1;
			redacted_q.push_back(tail);
		end
	endtask

	// Track register writes, predict on input transactions, compare output transactions.
	always @(posedge clk or negedge arst_n) begin
		redacted_byte_t want;
		if (!arst_n) begin
			pat_lo = '0;
			pat_hi = '0;
			pat_len = 5'd1;
			for (int j = 0; j < MAX_PATTERN; j++)
				win[j] = '0;
			win_fill = 0;
			redacted_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					spr_pkg::REG_PAT_LO:  pat_lo = cfg_data;
					spr_pkg::REG_PAT_HI:  pat_hi = cfg_data;
					spr_pkg::REG_PAT_LEN: pat_len = cfg_data[4:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_redaction(s_tdata);
			if (m_tvalid && m_tready) begin
				if (redacted_q.size() == 0) begin
					$error("out_byte %h (last %b) arrived with no result expected",
						m_tdata, m_tlast);
					fail_count++;
				end else begin
					want = redacted_q.pop_front();
					if (m_tdata !== want.value) begin
						$error("out_byte mismatch: expected %h, actual %h",
							want.value, m_tdata);
						fail_count++;
					end
					if (m_tlast !== want.last) begin
						$error("last mismatch: expected %b, actual %b", want.last, m_tlast);
						fail_count++;
					end
				end
			end
			pending = redacted_q.size();
		end
	end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the stream pattern redactor: clock, reset, stimulus and verdict.

module tb_top;

	localparam int MAX_PATTERN     = 16;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int HOLD_CYCLES     = 300;
	localparam int SETTLE_CYCLES   = 24;
	localparam int LIMIT           = 1000000;

	localparam logic [7:0] B_BYTE = 8'h62;
	localparam logic [7:0] C_BYTE = 8'h63;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata   = '0;   // [7:0] in_byte
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [7:0]                    m_tdata;          // [7:0] out_byte
	logic                          m_tlast;
	logic                          cfg_we    = 1'b0;
	logic [spr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]                   cfg_data  = '0;

	int  fail_count;
	int  pending;
	int  cycle_cnt  = 0;
	int  bytes_sent = 0;
	bit  no_gaps    = 1'b0;
	bit  hold_req   = 1'b0;

	// Pattern currently programmed, as the stimulus sees it.
	logic [7:0]  cur_pat [MAX_PATTERN];
	int unsigned cur_len = 1;

	stream_pattern_redactor_core #(
		.MAX_PATTERN(MAX_PATTERN)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	spr_checker #(
		.MAX_PATTERN(MAX_PATTERN)
	) redaction_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Clock with a period of four.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Byte from a small alphabet rich in 'a', with some fully random bytes.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return spr_pkg::A_BYTE;
			3:       return B_BYTE;
			4:       return spr_pkg::FILL_BYTE;
			5:       return 8'h00;
			6:       return C_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [63:0] pick_pattern_word();
		logic [63:0] w;
		if ($urandom_range(0, 3) == 0)
			return {$urandom, $urandom};
		for (int i = 0; i < 8; i++)
			w[8*i +: 8] = pick_byte();
		return w;
	endfunction

	// Offer one byte and hold it until the transaction completes, then maybe idle for a random gap.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		s_tdata <= b;
		s_tvalid <= 1'b1;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		bytes_sent++;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every owed byte has come out and the block has settled.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Program all three registers; only called while the block is idle.
	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
			input logic [63:0] len_word);
		cfg_we <= 1'b1;
		cfg_index <= spr_pkg::REG_PAT_LO;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= spr_pkg::REG_PAT_HI;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= spr_pkg::REG_PAT_LEN;
		cfg_data <= len_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		for (int i = 0; i < MAX_PATTERN; i++)
			cur_pat[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
		if (len_word[4:0] == 5'd0)
			cur_len = 1;
		else if (len_word[4:0] > MAX_PATTERN)
			cur_len = MAX_PATTERN;
		else
			cur_len = len_word[4:0];
	endtask

	// Receiver: random ready runs and gaps, plus one long hold-off on request.
	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Stimulus: directed cases first, then random phases with fresh settings.
	initial begin : stimulus
		int          r;
		int          k;
		int          start;
		int unsigned n;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] len_word;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the pattern is a single NUL byte, which vanishes on a match.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(spr_pkg::NEWLINE_BYTE);
		wait_idle();

		// Sixteen 'a' pattern: fifteen pending bytes flushed by a line end.
		configure({8{spr_pkg::A_BYTE}}, {8{spr_pkg::A_BYTE}}, 64'd16);
		repeat (15) send_byte(spr_pkg::A_BYTE);
		send_byte(spr_pkg::NEWLINE_BYTE);

		// Leave bytes pending, then shorten the pattern below the window fill.
		repeat (5) send_byte(B_BYTE);
		wait_idle();
		configure({48'h0, spr_pkg::A_BYTE, B_BYTE}, 64'h0, 64'd2);
		send_byte(spr_pkg::A_BYTE);
		send_byte(spr_pkg::NEWLINE_BYTE);

		// Random phases.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					lo = '1;
					hi = '1;
					len_word = 64'd16;
				end
				1: begin
					lo = {8{spr_pkg::A_BYTE}};
					hi = {8{spr_pkg::A_BYTE}};
					len_word = {$urandom, $urandom};
					len_word[4:0] = 5'd31;
				end
				2: begin
					lo = pick_pattern_word();
					hi = '0;
					len_word = 64'd0;
				end
				default: begin
					lo = pick_pattern_word();
					hi = pick_pattern_word();
					case ($urandom_range(0, 9))
						0:       n = 0;
						1:       n = 16;
						2:       n = $urandom_range(17, 31);
						3, 4, 5: n = $urandom_range(1, 15);
						default: n = $urandom_range(1, 4);
					endcase
					len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
					len_word[4:0] = n[4:0];
				end
			endcase
			configure(lo, hi, len_word);
			no_gaps = (p % 3 == 1);
			if (p == 4)
				hold_req = 1'b1;

			start = bytes_sent;
			while (bytes_sent - start < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					// Whole pattern copy.
					for (int i = 0; i < cur_len; i++)
						send_byte(cur_pat[i]);
				end else if (r < 65) begin
					// Pattern prefix broken by a single flipped bit.
					k = $urandom_range(0, cur_len - 1);
					for (int i = 0; i < k; i++)
						send_byte(cur_pat[i]);
					send_byte(cur_pat[k] ^ (8'h01 << $urandom_range(0, 7)));
				end else if (r < 90) begin
					send_byte(pick_byte());
				end else begin
					send_byte(spr_pkg::NEWLINE_BYTE);
				end
			end
		end

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
